>>> sv/dac_offset_calibration_search_defines.svh
// assertion macros for the dac offset calibration search block
// used by the rtl files in this folder; no other dependencies
`ifndef DAC_OFFSET_CALIBRATION_SEARCH_DEFINES_SVH
`define DAC_OFFSET_CALIBRATION_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DOCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DOCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/docs_pkg.sv
// shared types and constants for the dac offset calibration search block
// no dependencies
package docs_pkg;

    // sizes
    localparam int CHANNELS    = 16;
    localparam int MAX_SAMPLES = 32;
    localparam int DAC_BITS    = 12;
    localparam int CH_BITS     = 4;
    localparam int MOVE_BITS   = 5;
    localparam int STEP_BITS   = DAC_BITS + 1;

    localparam logic [DAC_BITS-1:0]  CODE_MAX  = {DAC_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0] STEP_INIT = {1'b1, {DAC_BITS{1'b0}}};
    localparam logic [MOVE_BITS-1:0] MAX_MOVES = MOVE_BITS'(MAX_SAMPLES - 1);

    // input kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_RECALL = 2'd2;

    // result status codes
    localparam logic [2:0] ST_SEARCH   = 3'd0;
    localparam logic [2:0] ST_CONVERGE = 3'd1;
    localparam logic [2:0] ST_GAVE_UP  = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_RECALL   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET    = 2'd0;
    localparam logic [1:0] CFG_HALF_BAND = 2'd1;
    localparam logic [1:0] CFG_HEADER    = 2'd2;

    localparam logic [15:0] TARGET_RST    = 16'd26844;
    localparam logic [14:0] HALF_BAND_RST = 15'd250;
    localparam logic [3:0]  HEADER_RST    = 4'b0101;

    typedef struct packed {
        logic [15:0] target;
        logic [14:0] half_band;
        logic [3:0]  dac_header;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CH_BITS-1:0] channel;
        logic [15:0]        adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [CH_BITS-1:0]   channel_out;
        logic [DAC_BITS-1:0]  dac_code;
        logic [15:0]          dac_word;
        logic [MOVE_BITS-1:0] moves;
    } t_out_item;

endpackage

>>> sv/docs_cfg_regs.sv
// configuration registers: target, half band and dac command header
// depends on docs_pkg
module docs_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_wdata,
    output docs_pkg::t_cfg  o_cfg
);
    import docs_pkg::*;

    t_cfg r_cfg;

    // write by index, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target     <= TARGET_RST;
            r_cfg.half_band  <= HALF_BAND_RST;
            r_cfg.dac_header <= HEADER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET:    r_cfg.target     <= i_cfg_wdata;
                CFG_HALF_BAND: r_cfg.half_band  <= i_cfg_wdata[14:0];
                CFG_HEADER:    r_cfg.dac_header <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/docs_search_core.sv
// search state and per-item decision logic, plus the stored code per channel
// depends on docs_pkg and the assertion macro header
`include "dac_offset_calibration_search_defines.svh"

module docs_search_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  docs_pkg::t_in_item  i_item,
    input  docs_pkg::t_cfg      i_cfg,
    output docs_pkg::t_out_item o_result
);
    import docs_pkg::*;

    localparam logic [CH_BITS:0] CH_LIMIT = (CH_BITS+1)'(CHANNELS);

    logic                 r_searching, n_searching;
    logic                 r_raising, n_raising;
    logic                 r_first, n_first;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [DAC_BITS-1:0]  r_dac, n_dac;
    logic [MOVE_BITS-1:0] r_moves, n_moves;
    logic [CH_BITS-1:0]   r_active, n_active;
    logic [DAC_BITS-1:0]  r_codes [CHANNELS];

    logic                 chan_ok;
    logic [16:0]          upper_edge;
    logic [16:0]          sample_plus;
    logic                 above;
    logic                 below;
    logic                 raise_pre;
    logic                 halve;
    logic                 raise_new;
    logic [STEP_BITS-1:0] step_new;
    logic [STEP_BITS-1:0] up_sum;
    logic [STEP_BITS-1:0] down_diff;
    logic [DAC_BITS-1:0]  moved_dac;
    logic                 store_code;
    logic [2:0]           res_status;
    logic [CH_BITS-1:0]   res_chan;
    logic [DAC_BITS-1:0]  res_code;

    // band edges without wrap
    assign chan_ok     = {1'b0, i_item.channel} < CH_LIMIT;
    assign upper_edge  = {1'b0, i_cfg.target} + {2'b00, i_cfg.half_band};
    assign sample_plus = {1'b0, i_item.adc_sample} + {2'b00, i_cfg.half_band};
    assign above       = {1'b0, i_item.adc_sample} > upper_edge;
    assign below       = sample_plus < {1'b0, i_cfg.target};

    // direction and step; the first sample seeds the direction so the step halves
    assign raise_pre = r_first ? below : r_raising;
    assign halve     = (below && raise_pre) || (above && !raise_pre);
    assign raise_new = halve ? above : raise_pre;
    assign step_new  = halve ? (r_step >> 1) : r_step;

    // move with clamp at top; a step down past zero gives code one
    assign up_sum    = {1'b0, r_dac} + step_new;
    assign down_diff = {1'b0, r_dac} - step_new;
    always_comb begin
        if (raise_new) begin
            moved_dac = (up_sum > {1'b0, CODE_MAX}) ? CODE_MAX : up_sum[DAC_BITS-1:0];
        end else if ({1'b0, r_dac} < step_new) begin
            moved_dac = DAC_BITS'(1);
        end else begin
            moved_dac = down_diff[DAC_BITS-1:0];
        end
    end

    // next state and result for the item at hand
    always_comb begin
        n_searching = r_searching;
        n_raising   = r_raising;
        n_first     = r_first;
        n_step      = r_step;
        n_dac       = r_dac;
        n_moves     = r_moves;
        n_active    = r_active;
        store_code  = 1'b0;
        res_status  = ST_IGNORED;
        res_chan    = r_active;
        res_code    = r_dac;
        priority if (i_item.kind == KIND_START && chan_ok) begin
            n_active    = i_item.channel;
            n_searching = 1'b1;
            n_first     = 1'b1;
            n_raising   = 1'b0;
            n_step      = STEP_INIT;
            n_dac       = '0;
            n_moves     = '0;
            res_status  = ST_SEARCH;
            res_chan    = i_item.channel;
            res_code    = '0;
        end else if (i_item.kind == KIND_RECALL && chan_ok) begin
            res_status = ST_RECALL;
            res_chan   = i_item.channel;
            res_code   = r_codes[i_item.channel];
        end else if (i_item.kind == KIND_SAMPLE && r_searching) begin
            if (!above && !below) begin
                n_searching = 1'b0;
                store_code  = 1'b1;
                res_status  = ST_CONVERGE;
            end else if (r_moves >= MAX_MOVES) begin
                n_searching = 1'b0;
                store_code  = 1'b1;
                res_status  = ST_GAVE_UP;
            end else begin
                n_first    = 1'b0;
                n_raising  = raise_new;
                n_step     = step_new;
                n_dac      = moved_dac;
                n_moves    = r_moves + MOVE_BITS'(1);
                res_status = ST_SEARCH;
                res_code   = moved_dac;
            end
        end else begin
            res_status = ST_IGNORED;
        end
    end

    assign o_result.status      = res_status;
    assign o_result.channel_out = res_chan;
    assign o_result.dac_code    = res_code;
    assign o_result.dac_word    = 16'({i_cfg.dac_header, res_code});
    assign o_result.moves       = (res_status == ST_SEARCH) ? n_moves : r_moves;

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching <= 1'b0;
            r_raising   <= 1'b0;
            r_first     <= 1'b0;
            r_step      <= STEP_INIT;
            r_dac       <= '0;
            r_moves     <= '0;
            r_active    <= '0;
        end else if (i_fire) begin
            r_searching <= n_searching;
            r_raising   <= n_raising;
            r_first     <= n_first;
            r_step      <= n_step;
            r_dac       <= n_dac;
            r_moves     <= n_moves;
            r_active    <= n_active;
        end
    end

    // stored code per channel, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_codes[i] <= '0;
            end
        end else if (i_fire && store_code) begin
            r_codes[r_active] <= r_dac;
        end
    end

    `DOCS_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, i_fire && i_item.kind == KIND_START, r_searching && r_moves == '0 && r_dac == '0, "start did not reset the search")
    `DOCS_ASSERT_NEXT(a_move_limit, i_clk, i_rst_n, i_fire && i_item.kind == KIND_SAMPLE && r_searching && r_moves == MAX_MOVES, !r_searching, "search ran past the move limit")
    `DOCS_ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_searching, r_step <= STEP_INIT && r_moves <= MAX_MOVES, "step or move count out of range")

endmodule

>>> sv/docs_out_stage.sv
// result register between the decision logic and the output channel
// depends on docs_pkg
module docs_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  docs_pkg::t_out_item i_result,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output docs_pkg::t_out_item o_out_item
);
    import docs_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // valid flag: set on load, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

>>> sv/dac_offset_calibration_search.sv
// DAC offset calibration by step-halving search, one search per channel with
// the final code kept for recall. A start item drives code 0 with step 4096;
// each sample item during a search either converges, gives up after 31 moves,
// or yields the next code to drive. The block takes one item per clock while
// the output is taken: an item sits in the input register, the decision logic
// and the search state update in that cycle, and the result lands in the
// output register.
// Configuration writes take effect on the next clock; write them only while
// no item is in flight.
// depends on docs_pkg, docs_cfg_regs, docs_search_core, docs_out_stage
`include "dac_offset_calibration_search_defines.svh"

module dac_offset_calibration_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  docs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output docs_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata
);
    import docs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // item moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    docs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    docs_search_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    docs_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `DOCS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && o_out_valid && !i_out_ready, r_in_valid && $stable(r_in_item), "stalled item lost from input register")
    `DOCS_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !r_in_valid, o_in_ready, "empty input register not ready")
    `DOCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "waiting result changed before it was taken")

endmodule
